@@ rtl/core/pps_pkg.sv @@
// preemptive priority scheduler: shared constants, table entry type and codes
// no dependencies
`timescale 1ns / 1ps

package pps_pkg;

  localparam int unsigned SLOTS  = 16;
  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
  localparam int unsigned TIME_W = 16;
  localparam int unsigned PRIO_W = 10;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned PC_W   = 5;
  localparam int unsigned SLOT_FIELD_W = 4;

  localparam logic [PRIO_W-1:0] PRIO_LIMIT = PRIO_W'(999);
  localparam logic [TIME_W-1:0] TIME_MAX   = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef struct packed {
    logic [TIME_W-1:0] remaining;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] arrival;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    entry_t            data;
  } tbl_wr_t;

endpackage

@@ rtl/core/pps_req_if.sv @@
// request channel of the scheduler: valid/ready handshake with one command
// depends on pps_pkg
`timescale 1ns / 1ps

interface pps_req_if;
  import pps_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [MODE_W-1:0]       mode;
  logic [SLOT_FIELD_W-1:0] slot;
  logic [TIME_W-1:0]       burst;
  logic [TIME_W-1:0]       arrival;
  logic [PRIO_W-1:0]       priority_req;

  modport source (output valid, mode, slot, burst, arrival, priority_req, input ready);
  modport sink   (input valid, mode, slot, burst, arrival, priority_req, output ready);
endinterface

@@ rtl/core/pps_rsp_if.sv @@
// response channel of the scheduler: valid/ready handshake with one result
// depends on pps_pkg
`timescale 1ns / 1ps

interface pps_rsp_if;
  import pps_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [TIME_W-1:0]       time_now;
  logic                    ran;
  logic [SLOT_FIELD_W-1:0] run_slot;
  logic                    finished;
  logic [TIME_W-1:0]       waiting;
  logic [TIME_W-1:0]       turnaround;
  logic                    all_done;

  modport source (output valid, time_now, ran, run_slot, finished, waiting, turnaround,
                  all_done, input ready);
  modport sink   (input valid, time_now, ran, run_slot, finished, waiting, turnaround,
                  all_done, output ready);
endinterface

@@ rtl/core/preemptive_priority_scheduler_top.sv @@
// preemptive priority scheduler top level: command sequencer, slot walk and result register
// depends on pps_pkg, pps_req_if, pps_rsp_if and pps_table
`timescale 1ns / 1ps

// Every request transaction gives exactly one response transaction. Clear, load and the
// unused mode go from acceptance straight to the output state, as does a tick on which
// every slot in use is already done. A working tick reads the current slot and updates it
// (skipped when the current slot lies outside the slots in use), then walks the slots in
// use; the first tick after reset or clear first does an earliest-arrival walk. The
// process table sits behind a single registered read port and is walked one slot per
// cycle. A request is taken only while the sequencer is idle; a finished result waits in
// the output register while the next request is accepted, and the sequencer stalls before
// loading the next result until that one has been taken. The user must write process_count
// through cfg_we_i / cfg_wdata_i only while no request is in flight; the block does not enforce it.
module preemptive_priority_scheduler_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [pps_pkg::PC_W-1:0] cfg_wdata_i,
  pps_req_if.sink                  req_i,
  pps_rsp_if.source                rsp_o
);
  import pps_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_CUR_RD = 3'd2;
  localparam logic [2:0] ST_CUR_WB = 3'd3;
  localparam logic [2:0] ST_OUT    = 3'd4;

  logic [2:0]        state_q;
  logic [PC_W-1:0]   pc_q;
  logic [SLOTS-1:0]  done_q;
  logic [SLOT_W-1:0] cur_q;
  logic [TIME_W-1:0] tick_q;
  logic              started_q;

  // walk state
  logic              first_q;
  logic [CNT_W-1:0]  k_q;
  logic              pend_q;
  logic [SLOT_W-1:0] pidx_q;
  logic              found_q;
  logic [SLOT_W-1:0] best_idx_q;
  logic [TIME_W-1:0] best_arr_q;
  logic [PRIO_W-1:0] best_prio_q;

  // result being built
  logic [TIME_W-1:0] res_now_q;
  logic [SLOT_W-1:0] res_slot_q;
  logic              res_ran_q;
  logic              res_fin_q;
  logic [TIME_W-1:0] res_wt_q;
  logic [TIME_W-1:0] res_ta_q;

  // output register
  logic              ovld_q;
  logic [TIME_W-1:0] o_now_q;
  logic [SLOT_W-1:0] o_slot_q;
  logic              o_ran_q;
  logic              o_fin_q;
  logic [TIME_W-1:0] o_wt_q;
  logic [TIME_W-1:0] o_ta_q;
  logic              o_all_q;

  logic [CNT_W-1:0]  n_act;
  logic [SLOTS-1:0]  act_mask;
  logic              all_done;
  logic [TIME_W:0]   next_t;
  logic              req_acc;
  logic              issue;
  logic              out_load;
  logic              mem_clr;
  tbl_wr_t           tbl_wr;
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  entry_t            rd_data;

  // current slot evaluation
  logic              cur_act;
  logic              run_now;
  logic [TIME_W-1:0] rem_new;
  logic              fin_now;
  logic signed [TIME_W+2:0] wt_raw;
  logic signed [TIME_W+2:0] ta_raw;
  logic [TIME_W-1:0] wt_cl;
  logic [TIME_W-1:0] ta_cl;

  // walk comparison
  logic              elig;
  logic              better;
  logic              take;

  assign n_act = (pc_q >= PC_W'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(pc_q);

  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      act_mask[k] = (CNT_W'(k) < n_act);
    end
  end

  assign all_done = &(done_q | ~act_mask);
  assign next_t   = {1'b0, tick_q} + 1'b1;
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc  = req_i.valid && req_i.ready;
  assign issue    = (state_q == ST_SCAN) && (k_q < n_act);
  assign out_load = (state_q == ST_OUT) && (!ovld_q || rsp_o.ready);
  assign cur_act  = ({1'b0, cur_q} < n_act);

  always_comb begin
    run_now = (rd_data.remaining != '0) && (rd_data.arrival <= tick_q);
    rem_new = run_now ? rd_data.remaining - 1'b1 : rd_data.remaining;
    fin_now = (rem_new == '0) && !done_q[cur_q];
    wt_raw  = $signed({2'b00, next_t}) - $signed({3'b000, rd_data.burst})
              - $signed({3'b000, rd_data.arrival});
    ta_raw  = $signed({2'b00, next_t}) - $signed({3'b000, rd_data.arrival});
    if (wt_raw < 0) begin
      wt_cl = '0;
    end else if (wt_raw > $signed({3'b000, TIME_MAX})) begin
      wt_cl = TIME_MAX;
    end else begin
      wt_cl = wt_raw[TIME_W-1:0];
    end
    if (ta_raw < 0) begin
      ta_cl = '0;
    end else if (ta_raw > $signed({3'b000, TIME_MAX})) begin
      ta_cl = TIME_MAX;
    end else begin
      ta_cl = ta_raw[TIME_W-1:0];
    end
  end

  always_comb begin
    if (first_q) begin
      elig   = 1'b1;
      better = rd_data.arrival < best_arr_q;
    end else begin
      elig   = !done_q[pidx_q] && ({1'b0, rd_data.arrival} <= next_t)
               && (rd_data.prio < PRIO_LIMIT);
      better = (rd_data.prio < best_prio_q)
               || ((rd_data.prio == best_prio_q) && (rd_data.arrival < best_arr_q));
    end
    take = pend_q && elig && (!found_q || better);
  end

  always_comb begin
    mem_clr = req_acc && (mode_e'(req_i.mode) == MODE_CLEAR);
    tbl_wr  = '0;
    if (req_acc && (mode_e'(req_i.mode) == MODE_LOAD)) begin
      tbl_wr.en             = 1'b1;
      tbl_wr.addr           = req_i.slot[SLOT_W-1:0];
      tbl_wr.data.remaining = req_i.burst;
      tbl_wr.data.burst     = req_i.burst;
      tbl_wr.data.arrival   = req_i.arrival;
      tbl_wr.data.prio      = req_i.priority_req;
    end else if ((state_q == ST_CUR_WB) && run_now) begin
      tbl_wr.en             = 1'b1;
      tbl_wr.addr           = cur_q;
      tbl_wr.data           = rd_data;
      tbl_wr.data.remaining = rem_new;
    end
    rd_en   = 1'b0;
    rd_addr = cur_q;
    if (issue) begin
      rd_en   = 1'b1;
      rd_addr = k_q[SLOT_W-1:0];
    end else if ((state_q == ST_CUR_RD) && cur_act) begin
      rd_en   = 1'b1;
    end
  end

  pps_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (mem_clr),
    .wr_i      (tbl_wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      done_q      <= '0;
      cur_q       <= '0;
      tick_q      <= '0;
      started_q   <= 1'b0;
      first_q     <= 1'b0;
      k_q         <= '0;
      pend_q      <= 1'b0;
      pidx_q      <= '0;
      found_q     <= 1'b0;
      best_idx_q  <= '0;
      best_arr_q  <= '0;
      best_prio_q <= '0;
      res_now_q   <= '0;
      res_slot_q  <= '0;
      res_ran_q   <= 1'b0;
      res_fin_q   <= 1'b0;
      res_wt_q    <= '0;
      res_ta_q    <= '0;
      ovld_q      <= 1'b0;
      o_now_q     <= '0;
      o_slot_q    <= '0;
      o_ran_q     <= 1'b0;
      o_fin_q     <= 1'b0;
      o_wt_q      <= '0;
      o_ta_q      <= '0;
      o_all_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pc_q <= cfg_wdata_i;
      end
      if (out_load) begin
        ovld_q <= 1'b1;
      end else if (ovld_q && rsp_o.ready) begin
        ovld_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (req_acc) begin
            res_now_q  <= mem_clr ? '0 : tick_q;
            res_slot_q <= mem_clr ? '0 : cur_q;
            res_ran_q  <= 1'b0;
            res_fin_q  <= 1'b0;
            res_wt_q   <= '0;
            res_ta_q   <= '0;
            k_q        <= '0;
            pend_q     <= 1'b0;
            found_q    <= 1'b0;
            case (mode_e'(req_i.mode))
              MODE_CLEAR: begin
                done_q    <= '0;
                cur_q     <= '0;
                tick_q    <= '0;
                started_q <= 1'b0;
                state_q   <= ST_OUT;
              end
              MODE_LOAD: begin
                done_q[req_i.slot[SLOT_W-1:0]] <= 1'b0;
                state_q <= ST_OUT;
              end
              MODE_TICK: begin
                if ((n_act != '0) && !all_done) begin
                  if (started_q) begin
                    state_q <= ST_CUR_RD;
                  end else begin
                    first_q <= 1'b1;
                    state_q <= ST_SCAN;
                  end
                end else begin
                  state_q <= ST_OUT;
                end
              end
              default: begin
                state_q <= ST_OUT;
              end
            endcase
          end
        end

        ST_SCAN: begin
          k_q    <= issue ? k_q + 1'b1 : k_q;
          pend_q <= issue;
          pidx_q <= k_q[SLOT_W-1:0];
          if (take) begin
            found_q     <= 1'b1;
            best_idx_q  <= pidx_q;
            best_arr_q  <= rd_data.arrival;
            best_prio_q <= rd_data.prio;
          end
          if (!issue && !pend_q) begin
            if (first_q) begin
              cur_q     <= best_idx_q;
              started_q <= 1'b1;
              first_q   <= 1'b0;
              state_q   <= ST_CUR_RD;
            end else begin
              if (found_q) begin
                cur_q <= best_idx_q;
              end
              if (tick_q != TIME_MAX) begin
                tick_q <= tick_q + 1'b1;
              end
              state_q <= ST_OUT;
            end
          end
        end

        ST_CUR_RD: begin
          res_slot_q <= cur_q;
          k_q        <= '0;
          pend_q     <= 1'b0;
          found_q    <= 1'b0;
          state_q    <= cur_act ? ST_CUR_WB : ST_SCAN;
        end

        ST_CUR_WB: begin
          res_ran_q <= run_now;
          res_fin_q <= fin_now;
          if (fin_now) begin
            done_q[cur_q] <= 1'b1;
            res_wt_q      <= wt_cl;
            res_ta_q      <= ta_cl;
          end
          state_q <= ST_SCAN;
        end

        ST_OUT: begin
          if (out_load) begin
            o_now_q  <= res_now_q;
            o_slot_q <= res_slot_q;
            o_ran_q  <= res_ran_q;
            o_fin_q  <= res_fin_q;
            o_wt_q   <= res_wt_q;
            o_ta_q   <= res_ta_q;
            o_all_q  <= all_done;
            state_q  <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp_o.valid      = ovld_q;
  assign rsp_o.time_now   = o_now_q;
  assign rsp_o.ran        = o_ran_q;
  assign rsp_o.run_slot   = SLOT_FIELD_W'(o_slot_q);
  assign rsp_o.finished   = o_fin_q;
  assign rsp_o.waiting    = o_wt_q;
  assign rsp_o.turnaround = o_ta_q;
  assign rsp_o.all_done   = o_all_q;

endmodule

@@ rtl/core/pps_table.sv @@
// process slot table: one write port, one registered read port, per-entry valid bits
// depends on pps_pkg; an entry never written since the last clear reads as zero
`timescale 1ns / 1ps

module pps_table (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   clr_i,
  input  pps_pkg::tbl_wr_t       wr_i,
  input  logic                   rd_en_i,
  input  logic [pps_pkg::SLOT_W-1:0] rd_addr_i,
  output pps_pkg::entry_t        rd_data_o
);
  import pps_pkg::*;

  entry_t            mem [SLOTS];
  entry_t            rdata_q;
  logic [SLOTS-1:0]  vld_q;
  logic              rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (clr_i) begin
        vld_q <= '0;
      end else if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : '0;

endmodule
